>>> rtl/owlcd_pkg.sv
`default_nettype none

package owlcd_pkg;

  localparam int TICK_COUNT_WIDTH = 16;
  localparam int TICK_REG_W       = 16;
  localparam int CFG_INDEX_W      = 3;
  localparam int CFG_DATA_W       = 16;
  localparam int PULSE_INDEX_W    = 5;
  localparam int LAST_PULSE       = 31;

  localparam logic [TICK_REG_W-1:0] ONE_LOW_RESET    = 16'd1;
  localparam logic [TICK_REG_W-1:0] ONE_HIGH_RESET   = 16'd30;
  localparam logic [TICK_REG_W-1:0] ZERO_LOW_RESET   = 16'd20;
  localparam logic [TICK_REG_W-1:0] ZERO_HIGH_RESET  = 16'd150;
  localparam logic [TICK_REG_W-1:0] LATCH_LOW_RESET  = 16'd250;
  localparam logic [TICK_REG_W-1:0] LATCH_HIGH_RESET = 16'd500;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ONE_LOW    = 3'd0,
    REG_ONE_HIGH   = 3'd1,
    REG_ZERO_LOW   = 3'd2,
    REG_ZERO_HIGH  = 3'd3,
    REG_LATCH_LOW  = 3'd4,
    REG_LATCH_HIGH = 3'd5,
    REG_BACKLIGHT  = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_ZERO  = 2'd0,
    KIND_ONE   = 2'd1,
    KIND_LATCH = 2'd2
  } pulse_kind_t;

  typedef struct packed {
    logic                  cmd;
    logic [7:0]            byte_value;
    logic                  is_data;
  } in_t;

  typedef struct packed {
    logic                  line_level;
    logic                  busy_res;
    logic                  rejected;
  } out_t;

  typedef struct packed {
    logic [TICK_REG_W-1:0] one_low_ticks;
    logic [TICK_REG_W-1:0] one_high_ticks;
    logic [TICK_REG_W-1:0] zero_low_ticks;
    logic [TICK_REG_W-1:0] zero_high_ticks;
    logic [TICK_REG_W-1:0] latch_low_ticks;
    logic [TICK_REG_W-1:0] latch_high_ticks;
    logic                  backlight_on;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/owlcd_phase.sv
`default_nettype none

module owlcd_phase (
  input  owlcd_pkg::cfg_t                               cfg,
  input  logic [owlcd_pkg::PULSE_INDEX_W-1:0]           pulse_index,
  input  logic                                          in_high_phase,
  input  logic [7:0]                                    held_byte,
  input  logic                                          held_select,
  output logic [owlcd_pkg::TICK_COUNT_WIDTH-1:0]        phase_len
);
  import owlcd_pkg::*;

  logic [3:0]            nybble;
  pulse_kind_t           kind;
  logic [TICK_REG_W-1:0] sel_ticks;
  logic [31:0]           sel_ext;
  logic [TICK_COUNT_WIDTH-1:0] trunc_len;

  assign nybble = pulse_index[4] ? held_byte[3:0] : held_byte[7:4];

  always_comb begin
    case (pulse_index[2:0])
      3'd0:    kind = cfg.backlight_on ? KIND_ONE : KIND_ZERO;
      3'd1:    kind = pulse_index[3] ? KIND_ZERO : KIND_ONE;
      3'd2:    kind = held_select ? KIND_ONE : KIND_ZERO;
      3'd3:    kind = nybble[3] ? KIND_ONE : KIND_ZERO;
      3'd4:    kind = nybble[2] ? KIND_ONE : KIND_ZERO;
      3'd5:    kind = nybble[1] ? KIND_ONE : KIND_ZERO;
      3'd6:    kind = nybble[0] ? KIND_ONE : KIND_ZERO;
      default: kind = KIND_LATCH;
    endcase
  end

  always_comb begin
    case (kind)
      KIND_ONE:   sel_ticks = in_high_phase ? cfg.one_high_ticks : cfg.one_low_ticks;
      KIND_LATCH: sel_ticks = in_high_phase ? cfg.latch_high_ticks : cfg.latch_low_ticks;
      default:    sel_ticks = in_high_phase ? cfg.zero_high_ticks : cfg.zero_low_ticks;
    endcase
  end

  // A length is taken modulo the counter range, and a length of zero counts as one.
  assign sel_ext   = 32'(sel_ticks);
  assign trunc_len = sel_ext[TICK_COUNT_WIDTH-1:0];
  assign phase_len = (trunc_len == '0) ? TICK_COUNT_WIDTH'(1) : trunc_len;

endmodule

`default_nettype wire

>>> rtl/one_wire_pulse_width_lcd_serializer.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_data   (cmd, byte_value, is_data)
// out_      output     out_valid / out_ready  out_data  (line_level, busy_res, rejected)
// cfg_      input      cfg_we                 cfg_index, cfg_wdata
//
// Every transfer on the input produces exactly one result, shown in the cycle after it.
// One item is taken per cycle while in_ready is high; the sequencer state and
// the result register are both updated at the edge of the input transfer.
// The input stalls only while a result is held in the output register and
// out_ready is low. Reset is synchronous and active low; the wire is high after it.

module one_wire_pulse_width_lcd_serializer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  owlcd_pkg::in_t                        in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output owlcd_pkg::out_t                       out_data,
  input  logic                                  cfg_we,
  input  logic [owlcd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [owlcd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import owlcd_pkg::*;

  cfg_t                        cfg_r;
  logic                        sending_r, sending_nxt;
  logic [PULSE_INDEX_W-1:0]    pulse_index_r, pulse_index_nxt;
  logic                        in_high_phase_r, in_high_phase_nxt;
  logic [TICK_COUNT_WIDTH-1:0] phase_counter_r, phase_counter_nxt;
  logic                        wire_level_r, wire_level_nxt;
  logic [7:0]                  held_byte_r;
  logic                        held_select_r;
  logic                        out_valid_r;
  out_t                        out_r, out_nxt;

  logic                        in_xfer;
  logic                        take_byte;
  logic [TICK_COUNT_WIDTH-1:0] phase_len;
  logic [TICK_COUNT_WIDTH-1:0] count_inc;
  logic                        rejected;

  owlcd_phase u_phase (
    .cfg           (cfg_r),
    .pulse_index   (pulse_index_r),
    .in_high_phase (in_high_phase_r),
    .held_byte     (held_byte_r),
    .held_select   (held_select_r),
    .phase_len     (phase_len)
  );

  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign take_byte = in_xfer && in_data.cmd && !sending_r;
  assign count_inc = phase_counter_r + TICK_COUNT_WIDTH'(1);

  always_comb begin
    sending_nxt       = sending_r;
    pulse_index_nxt   = pulse_index_r;
    in_high_phase_nxt = in_high_phase_r;
    phase_counter_nxt = phase_counter_r;
    wire_level_nxt    = wire_level_r;
    rejected          = 1'b0;
    if (in_data.cmd) begin
      if (sending_r) begin
        rejected = 1'b1;
      end else begin
        sending_nxt       = 1'b1;
        pulse_index_nxt   = '0;
        in_high_phase_nxt = 1'b0;
        phase_counter_nxt = '0;
        wire_level_nxt    = 1'b0;
      end
    end else if (sending_r) begin
      phase_counter_nxt = count_inc;
      if (count_inc >= phase_len) begin
        phase_counter_nxt = '0;
        if (!in_high_phase_r) begin
          in_high_phase_nxt = 1'b1;
          wire_level_nxt    = 1'b1;
        end else if (pulse_index_r == PULSE_INDEX_W'(LAST_PULSE)) begin
          sending_nxt       = 1'b0;
          pulse_index_nxt   = '0;
          in_high_phase_nxt = 1'b0;
          wire_level_nxt    = 1'b1;
        end else begin
          pulse_index_nxt   = pulse_index_r + PULSE_INDEX_W'(1);
          in_high_phase_nxt = 1'b0;
          wire_level_nxt    = 1'b0;
        end
      end
    end
    out_nxt.line_level = wire_level_nxt;
    out_nxt.busy_res   = sending_nxt;
    out_nxt.rejected   = rejected;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.one_low_ticks    <= ONE_LOW_RESET;
      cfg_r.one_high_ticks   <= ONE_HIGH_RESET;
      cfg_r.zero_low_ticks   <= ZERO_LOW_RESET;
      cfg_r.zero_high_ticks  <= ZERO_HIGH_RESET;
      cfg_r.latch_low_ticks  <= LATCH_LOW_RESET;
      cfg_r.latch_high_ticks <= LATCH_HIGH_RESET;
      cfg_r.backlight_on     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ONE_LOW:    cfg_r.one_low_ticks    <= cfg_wdata[TICK_REG_W-1:0];
        REG_ONE_HIGH:   cfg_r.one_high_ticks   <= cfg_wdata[TICK_REG_W-1:0];
        REG_ZERO_LOW:   cfg_r.zero_low_ticks   <= cfg_wdata[TICK_REG_W-1:0];
        REG_ZERO_HIGH:  cfg_r.zero_high_ticks  <= cfg_wdata[TICK_REG_W-1:0];
        REG_LATCH_LOW:  cfg_r.latch_low_ticks  <= cfg_wdata[TICK_REG_W-1:0];
        REG_LATCH_HIGH: cfg_r.latch_high_ticks <= cfg_wdata[TICK_REG_W-1:0];
        REG_BACKLIGHT:  cfg_r.backlight_on     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sending_r       <= 1'b0;
      pulse_index_r   <= '0;
      in_high_phase_r <= 1'b0;
      phase_counter_r <= '0;
      wire_level_r    <= 1'b1;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_xfer) begin
        sending_r       <= sending_nxt;
        pulse_index_r   <= pulse_index_nxt;
        in_high_phase_r <= in_high_phase_nxt;
        phase_counter_r <= phase_counter_nxt;
        wire_level_r    <= wire_level_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_ready) begin
        out_valid_r     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_byte) begin
      held_byte_r   <= in_data.byte_value;
      held_select_r <= in_data.is_data;
    end
    if (in_xfer) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_idle_wire_high: assert property (@(posedge clk) disable iff (!rst_n)
    !sending_r |-> (wire_level_r && pulse_index_r == '0 && phase_counter_r == '0))
    else $error("idle sequencer has a low wire or stale position");

  a_reject_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.rejected) |-> out_r.busy_res)
    else $error("rejected result while not busy");

  a_send_starts_low: assert property (@(posedge clk) disable iff (!rst_n)
    take_byte |=> (sending_r && !wire_level_r && !in_high_phase_r))
    else $error("accepted send did not start a low phase");

  a_counter_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_data.cmd && sending_r && count_inc >= phase_len)
    |=> phase_counter_r == '0)
    else $error("phase counter not cleared at the end of a phase");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (out_valid_r && out_r.busy_res == sending_r
                 && out_r.line_level == wire_level_r))
    else $error("result register does not match the sequencer state");

endmodule

`default_nettype wire

>>> tb/tb_one_wire_pulse_width_lcd_serializer.sv
module tb_one_wire_pulse_width_lcd_serializer;
  import owlcd_pkg::*;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SEND = 1'b1;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;
  localparam int N_ROWS = 14;
  localparam int N_PHASES = 14;
  localparam int ITEMS_PER_PHASE = 68;

  typedef struct packed {
    in_t  item;
    logic typed;
    out_t want;
  } line_row_t;

  // Rows with typed results are read straight off the behaviour after reset:
  // idle ticks keep the wire high, and a send while a byte is going out is dropped.
  localparam line_row_t LINE_ROWS [N_ROWS] = '{
    '{'{CMD_TICK, 8'h00, 1'b0}, 1'b1, '{1'b1, 1'b0, 1'b0}},
    '{'{CMD_TICK, 8'hFF, 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b0}},
    '{'{CMD_SEND, 8'hFF, 1'b1}, 1'b1, '{1'b0, 1'b1, 1'b0}},
    '{'{CMD_SEND, 8'h00, 1'b0}, 1'b1, '{1'b0, 1'b1, 1'b1}},
    '{'{CMD_SEND, 8'h5A, 1'b1}, 1'b1, '{1'b0, 1'b1, 1'b1}},
    '{'{CMD_TICK, 8'h00, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{CMD_TICK, 8'hFF, 1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{CMD_TICK, 8'h3C, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{CMD_TICK, 8'hC3, 1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{CMD_TICK, 8'h81, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{CMD_SEND, 8'hA5, 1'b0}, 1'b1, '{1'b0, 1'b1, 1'b1}},
    '{'{CMD_TICK, 8'h7E, 1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{CMD_TICK, 8'h00, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
    '{'{CMD_TICK, 8'hFF, 1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cfg_t line_cfg = '{ONE_LOW_RESET, ONE_HIGH_RESET, ZERO_LOW_RESET, ZERO_HIGH_RESET,
                     LATCH_LOW_RESET, LATCH_HIGH_RESET, 1'b0};
  logic sending = 1'b0;
  logic [PULSE_INDEX_W-1:0] pulse_idx = '0;
  logic high_phase = 1'b0;
  logic [TICK_COUNT_WIDTH-1:0] tick_cnt = '0;
  logic [7:0] held_byte = '0;
  logic held_sel = 1'b0;
  logic wire_level = 1'b1;

  out_t pending_levels [$];
  out_t oldest_level;
  int bad = 0;
  int stall_left = 0;
  bit no_gaps = 1'b0;

  one_wire_pulse_width_lcd_serializer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic pulse_kind_t kind_of_pulse(logic [PULSE_INDEX_W-1:0] p);
    logic [3:0] nyb;
    int b;
    nyb = p[4] ? held_byte[3:0] : held_byte[7:4];
    b = 6 - int'(p[2:0]);
    case (p[2:0])
      3'd0: return line_cfg.backlight_on ? KIND_ONE : KIND_ZERO;
      3'd1: return p[3] ? KIND_ZERO : KIND_ONE;
      3'd2: return held_sel ? KIND_ONE : KIND_ZERO;
      3'd7: return KIND_LATCH;
      default: return nyb[b] ? KIND_ONE : KIND_ZERO;
    endcase
  endfunction

  function automatic logic [TICK_COUNT_WIDTH-1:0] phase_ticks();
    logic [TICK_REG_W-1:0] len;
    logic [TICK_COUNT_WIDTH-1:0] cut;
    case (kind_of_pulse(pulse_idx))
      KIND_LATCH: len = high_phase ? line_cfg.latch_high_ticks : line_cfg.latch_low_ticks;
      KIND_ONE:   len = high_phase ? line_cfg.one_high_ticks : line_cfg.one_low_ticks;
      default:    len = high_phase ? line_cfg.zero_high_ticks : line_cfg.zero_low_ticks;
    endcase
    cut = TICK_COUNT_WIDTH'(len);
    return (cut == '0) ? TICK_COUNT_WIDTH'(1) : cut;
  endfunction

  function automatic out_t advance_wire(in_t it);
    out_t r;
    logic [TICK_COUNT_WIDTH-1:0] len;
    r.rejected = 1'b0;
    if (it.cmd == CMD_SEND) begin
      if (sending) begin
        r.rejected = 1'b1;
      end else begin
        held_byte = it.byte_value;
        held_sel = it.is_data;
        sending = 1'b1;
        pulse_idx = '0;
        high_phase = 1'b0;
        tick_cnt = '0;
        wire_level = 1'b0;
      end
    end else if (sending) begin
      len = phase_ticks();
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= len) begin
        tick_cnt = '0;
        if (!high_phase) begin
          high_phase = 1'b1;
          wire_level = 1'b1;
        end else if (pulse_idx == LAST_PULSE) begin
          sending = 1'b0;
          pulse_idx = '0;
          high_phase = 1'b0;
          wire_level = 1'b1;
        end else begin
          pulse_idx = pulse_idx + 1'b1;
          high_phase = 1'b0;
          wire_level = 1'b0;
        end
      end
    end
    r.line_level = wire_level;
    r.busy_res = sending;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ONE_LOW:    line_cfg.one_low_ticks = val;
      REG_ONE_HIGH:   line_cfg.one_high_ticks = val;
      REG_ZERO_LOW:   line_cfg.zero_low_ticks = val;
      REG_ZERO_HIGH:  line_cfg.zero_high_ticks = val;
      REG_LATCH_LOW:  line_cfg.latch_low_ticks = val;
      REG_LATCH_HIGH: line_cfg.latch_high_ticks = val;
      REG_BACKLIGHT:  line_cfg.backlight_on = val[0];
      default: ;
    endcase
  endtask

  task automatic offer_item(input in_t it, input logic typed, input out_t want);
    int gap;
    out_t got;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    got = advance_wire(it);
    pending_levels.push_back(typed ? want : got);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 7) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_levels.size() == 0) begin
        bad++;
        if (bad <= 10) $display("unexpected result: line_level %0b busy_res %0b rejected %0b",
                                out_data.line_level, out_data.busy_res, out_data.rejected);
      end else begin
        oldest_level = pending_levels.pop_front();
        if (out_data !== oldest_level) begin
          bad++;
          if (bad <= 10)
            $display("mismatch: line_level %0b/%0b busy_res %0b/%0b rejected %0b/%0b (exp/got)",
                     oldest_level.line_level, out_data.line_level,
                     oldest_level.busy_res, out_data.busy_res,
                     oldest_level.rejected, out_data.rejected);
        end
      end
    end
  end

  initial begin
    in_t it;
    logic [CFG_DATA_W-1:0] val;
    int r;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_ROWS; i++) offer_item(LINE_ROWS[i].item, LINE_ROWS[i].typed,
                                                LINE_ROWS[i].want);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      @(negedge clk);
      in_valid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clk);
      // Lengths are read live, so a byte still going out picks up the new timing at once.
      for (int idx = REG_ONE_LOW; idx <= REG_LATCH_HIGH; idx++) begin
        r = $urandom_range(0, 19);
        if (ph == 0) val = 16'd1;
        else if (ph == 1) val = 16'd0;
        else if (ph == 2) val = 16'hFFFF;
        else if (r == 0) val = 16'd0;
        else if (r < 3) val = 16'($urandom_range(3, 6));
        else val = 16'($urandom_range(1, 2));
        write_cfg(CFG_INDEX_W'(idx), val);
      end
      val = 16'($urandom);
      if (ph == 0 || ph == 2) val[0] = 1'b1;
      if (ph == 1) val[0] = 1'b0;
      write_cfg(REG_BACKLIGHT, val);
      if (ph == 3) write_cfg(REG_UNUSED, 16'($urandom));
      no_gaps = ($urandom_range(0, 3) == 0);

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        r = $urandom_range(0, 7);
        it.byte_value = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
        it.is_data = 1'($urandom_range(0, 1));
        if (sending) it.cmd = ($urandom_range(0, 24) == 0) ? CMD_SEND : CMD_TICK;
        else it.cmd = ($urandom_range(0, 9) < 8) ? CMD_SEND : CMD_TICK;
        offer_item(it, 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bad == 0 && pending_levels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/owlcd_pkg.sv
rtl/owlcd_phase.sv
rtl/one_wire_pulse_width_lcd_serializer.sv
tb/tb_one_wire_pulse_width_lcd_serializer.sv
